>>> rtl/tfp_pkg.sv
// Shared types and constants for the tuner front-panel controller.
`default_nettype none

package tfp_pkg;

  localparam int unsigned ChanW    = 14;
  localparam int unsigned StepW    = 7;
  localparam int unsigned VolW     = 6;
  localparam int unsigned GateW    = 10;
  localparam int unsigned TunerW   = 13;
  localparam int unsigned FreqW    = 18;
  localparam int unsigned FuncW    = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 14;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_CHAN_UPPER = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CHAN_LOWER = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_VOL_UPPER  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_VOL_LOWER  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_GATE_TICKS = 3'd4;

  // Reset values.
  localparam logic [ChanW-1:0] CHAN_UPPER_RST = 14'd15600;
  localparam logic [ChanW-1:0] CHAN_LOWER_RST = 14'd40;
  localparam logic [VolW-1:0]  VOL_UPPER_RST  = 6'd62;
  localparam logic [VolW-1:0]  VOL_LOWER_RST  = 6'd20;
  localparam logic [GateW-1:0] GATE_TICKS_RST = 10'd50;
  localparam logic [ChanW-1:0] CHAN_RST       = 14'd10000;
  localparam logic [StepW-1:0] STEP_RST       = 7'd1;
  localparam logic [VolW-1:0]  VOL_RST        = 6'd24;

  localparam logic [StepW-1:0] STEP_1   = 7'd1;
  localparam logic [StepW-1:0] STEP_10  = 7'd10;
  localparam logic [StepW-1:0] STEP_100 = 7'd100;
  localparam logic [VolW:0]    VOL_STEP = 7'd2;

  // Frequency map.
  localparam logic [ChanW-1:0]  FM_BASE_CHAN  = 14'd8000;
  localparam logic [ChanW-1:0]  FM_CHAN_SHIFT = 14'd7600;  // base minus tuner offset
  localparam logic [ChanW-1:0]  FM_TUNER_CAP  = 14'd8000;
  localparam logic [FreqW-1:0]  FM_BASE_KHZ   = 18'd30000;

  typedef enum logic [FuncW-1:0] {
    EV_TICK        = 3'd0,
    EV_TUNE_EDGE   = 3'd1,
    EV_TUNE_REL    = 3'd2,
    EV_STEP_BUTTON = 3'd3,
    EV_VOL_EDGE    = 3'd4,
    EV_VOL_REL     = 3'd5
  } event_e;

  typedef struct packed {
    logic [ChanW-1:0] channel;
    logic [StepW-1:0] step_size;
    logic [VolW-1:0]  volume;
  } panel_state_t;

  typedef struct packed {
    logic [ChanW-1:0] chan_upper;
    logic [ChanW-1:0] chan_lower;
    logic [VolW-1:0]  vol_upper;
    logic [VolW-1:0]  vol_lower;
    logic [GateW-1:0] gate_ticks;
  } panel_cfg_t;

endpackage

`default_nettype wire

>>> rtl/tuner_front_panel_controller_unit.sv
// Top level of the tuner front-panel controller.
// Every panel event transfer (tick, tune edge or release, step button, volume edge
// or release, or a spare code) yields exactly one result transfer carrying channel,
// step, volume, band, tuner channel and frequency in kHz. An event is taken every
// clock cycle unless the input is stalled; the clock that takes it loads the state
// registers, and the result register is loaded from them once it is free, after
// which the result itself can be transferred. Back-pressure on the result side
// stalls the input only once both stages hold an item. Configuration writes
// take effect on the next clock and should be made while no event is in flight.
`default_nettype none

module tuner_front_panel_controller_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [tfp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [tfp_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [tfp_pkg::FuncW-1:0]    func_i,
  input  wire logic                         direction_pin_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [tfp_pkg::ChanW-1:0]         channel_o,
  output logic [tfp_pkg::StepW-1:0]         step_size_o,
  output logic [tfp_pkg::VolW-1:0]         volume_o,
  output logic                              fm_band_o,
  output logic [tfp_pkg::TunerW-1:0]        tuner_channel_o,
  output logic [tfp_pkg::FreqW-1:0]         disp_freq_o
);
  import tfp_pkg::*;

  panel_state_t state;
  panel_cfg_t   cfg;
  logic         state_valid;
  logic         state_ready;

  tfp_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .direction_pin_i (direction_pin_i),
    .state_valid_o   (state_valid),
    .state_ready_i   (state_ready),
    .state_o         (state),
    .cfg_o           (cfg)
  );

  tfp_freq_map u_freq_map (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .state_valid_i   (state_valid),
    .state_ready_o   (state_ready),
    .state_i         (state),
    .chan_upper_i    (cfg.chan_upper),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .channel_o       (channel_o),
    .step_size_o     (step_size_o),
    .volume_o        (volume_o),
    .fm_band_o       (fm_band_o),
    .tuner_channel_o (tuner_channel_o),
    .disp_freq_o     (disp_freq_o)
  );

endmodule

`default_nettype wire

>>> rtl/tfp_ctrl.sv
// Panel event handling: configuration registers, gate counter and the tuning state.
`default_nettype none

module tfp_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [tfp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [tfp_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [tfp_pkg::FuncW-1:0]  func_i,
  input  wire logic                       direction_pin_i,
  output logic                            state_valid_o,
  input  wire logic                       state_ready_i,
  output tfp_pkg::panel_state_t           state_o,
  output tfp_pkg::panel_cfg_t             cfg_o
);
  import tfp_pkg::*;

  panel_cfg_t       cfg_q;
  logic [ChanW-1:0] chan_q, chan_d;
  logic [StepW-1:0] step_q, step_d;
  logic [VolW-1:0]  vol_q, vol_d;
  logic [GateW-1:0] gate_q, gate_d;
  logic             tune_held_q, tune_held_d;
  logic             vol_held_q, vol_held_d;
  logic             tune_ok_q, tune_ok_d;
  logic             step_ok_q, step_ok_d;
  logic             vol_ok_q, vol_ok_d;
  logic             valid_q, valid_d;
  logic             in_fire;

  logic [GateW:0]   gate_inc;
  logic [ChanW:0]   chan_sum, chan_dif;
  logic [ChanW-1:0] chan_up, chan_dn;
  logic [VolW:0]    vol_sum, vol_dif;
  logic [VolW-1:0]  vol_up, vol_dn;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chan_upper <= CHAN_UPPER_RST;
      cfg_q.chan_lower <= CHAN_LOWER_RST;
      cfg_q.vol_upper  <= VOL_UPPER_RST;
      cfg_q.vol_lower  <= VOL_LOWER_RST;
      cfg_q.gate_ticks <= GATE_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CHAN_UPPER: cfg_q.chan_upper <= cfg_data_i;
        CFG_CHAN_LOWER: cfg_q.chan_lower <= cfg_data_i;
        CFG_VOL_UPPER:  cfg_q.vol_upper  <= cfg_data_i[VolW-1:0];
        CFG_VOL_LOWER:  cfg_q.vol_lower  <= cfg_data_i[VolW-1:0];
        CFG_GATE_TICKS: cfg_q.gate_ticks <= cfg_data_i[GateW-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !valid_q || state_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Saturating candidates; the difference is negative when its top bit is set.
  assign gate_inc = {1'b0, gate_q} + {{GateW{1'b0}}, 1'b1};
  assign chan_sum = {1'b0, chan_q} + {{(ChanW+1-StepW){1'b0}}, step_q};
  assign chan_dif = {1'b0, chan_q} - {{(ChanW+1-StepW){1'b0}}, step_q};
  assign chan_up  = (chan_sum >= {1'b0, cfg_q.chan_upper}) ? cfg_q.chan_upper
                                                           : chan_sum[ChanW-1:0];
  assign chan_dn  = (chan_dif[ChanW] || (chan_dif[ChanW-1:0] < cfg_q.chan_lower))
                    ? cfg_q.chan_lower : chan_dif[ChanW-1:0];
  assign vol_sum  = {1'b0, vol_q} + VOL_STEP;
  assign vol_dif  = {1'b0, vol_q} - VOL_STEP;
  assign vol_up   = (vol_sum >= {1'b0, cfg_q.vol_upper}) ? cfg_q.vol_upper
                                                         : vol_sum[VolW-1:0];
  assign vol_dn   = (vol_dif[VolW] || (vol_dif[VolW-1:0] < cfg_q.vol_lower))
                    ? cfg_q.vol_lower : vol_dif[VolW-1:0];

  always_comb begin
    chan_d      = chan_q;
    step_d      = step_q;
    vol_d       = vol_q;
    gate_d      = gate_q;
    tune_held_d = tune_held_q;
    vol_held_d  = vol_held_q;
    tune_ok_d   = tune_ok_q;
    step_ok_d   = step_ok_q;
    vol_ok_d    = vol_ok_q;
    valid_d     = valid_q;
    if (in_fire) begin
      valid_d = 1'b1;
      case (func_i)
        EV_TICK: begin
          if (gate_q == '0) begin
            tune_ok_d = 1'b1;
            step_ok_d = 1'b1;
            vol_ok_d  = 1'b1;
          end
          gate_d = (gate_inc >= {1'b0, cfg_q.gate_ticks}) ? '0 : gate_inc[GateW-1:0];
        end
        EV_TUNE_EDGE: begin
          if (!tune_held_q) begin
            tune_held_d = 1'b1;
            if (tune_ok_q) begin
              tune_ok_d = 1'b0;
              chan_d    = direction_pin_i ? chan_up : chan_dn;
            end
          end
        end
        EV_TUNE_REL: tune_held_d = 1'b0;
        EV_STEP_BUTTON: begin
          if (step_ok_q) begin
            step_ok_d = 1'b0;
            if (step_q == STEP_1) begin
              step_d = STEP_10;
            end else if (step_q == STEP_10) begin
              step_d = STEP_100;
            end else begin
              step_d = STEP_1;
            end
          end
        end
        EV_VOL_EDGE: begin
          if (!vol_held_q) begin
            vol_held_d = 1'b1;
            if (vol_ok_q) begin
              vol_ok_d = 1'b0;
              vol_d    = direction_pin_i ? vol_dn : vol_up;
            end
          end
        end
        EV_VOL_REL: vol_held_d = 1'b0;
        default: ;
      endcase
    end else if (state_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q      <= CHAN_RST;
      step_q      <= STEP_RST;
      vol_q       <= VOL_RST;
      gate_q      <= '0;
      tune_held_q <= 1'b0;
      vol_held_q  <= 1'b0;
      tune_ok_q   <= 1'b0;
      step_ok_q   <= 1'b0;
      vol_ok_q    <= 1'b0;
      valid_q     <= 1'b0;
    end else begin
      chan_q      <= chan_d;
      step_q      <= step_d;
      vol_q       <= vol_d;
      gate_q      <= gate_d;
      tune_held_q <= tune_held_d;
      vol_held_q  <= vol_held_d;
      tune_ok_q   <= tune_ok_d;
      step_ok_q   <= step_ok_d;
      vol_ok_q    <= vol_ok_d;
      valid_q     <= valid_d;
    end
  end

  // The state registers only move when a new event is taken, so while an
  // event waits for the next stage they still hold exactly its outcome.
  assign state_valid_o     = valid_q;
  assign state_o.channel   = chan_q;
  assign state_o.step_size = step_q;
  assign state_o.volume    = vol_q;
  assign cfg_o             = cfg_q;

endmodule

`default_nettype wire

>>> rtl/tfp_freq_map.sv
// Result stage: band decision, tuner channel and displayed frequency.
`default_nettype none

module tfp_freq_map (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     state_valid_i,
  output logic                          state_ready_o,
  input  wire tfp_pkg::panel_state_t    state_i,
  input  wire logic [tfp_pkg::ChanW-1:0] chan_upper_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [tfp_pkg::ChanW-1:0]     channel_o,
  output logic [tfp_pkg::StepW-1:0]     step_size_o,
  output logic [tfp_pkg::VolW-1:0]      volume_o,
  output logic                          fm_band_o,
  output logic [tfp_pkg::TunerW-1:0]    tuner_channel_o,
  output logic [tfp_pkg::FreqW-1:0]     disp_freq_o
);
  import tfp_pkg::*;

  logic              valid_q;
  panel_state_t      res_q;
  logic              fm_d, fm_q;
  logic [ChanW-1:0]  fm_off;
  logic [ChanW-1:0]  tch_wide;
  logic [TunerW-1:0] tch_d, tch_q;
  logic [FreqW-1:0]  chan_ext, tch_ext, freq_d, freq_q;
  logic              take;

  assign state_ready_o = !valid_q || out_ready_i;
  assign take          = state_valid_i && state_ready_o;

  assign fm_d   = (state_i.channel >= FM_BASE_CHAN);
  assign fm_off = state_i.channel - FM_CHAN_SHIFT;

  always_comb begin
    if (!fm_d) begin
      tch_wide = state_i.channel;
    end else if (state_i.channel >= chan_upper_i) begin
      tch_wide = FM_TUNER_CAP;
    end else if (fm_off > FM_TUNER_CAP) begin
      tch_wide = FM_TUNER_CAP;
    end else begin
      tch_wide = fm_off;
    end
  end

  assign tch_d    = tch_wide[TunerW-1:0];
  assign chan_ext = {{(FreqW-ChanW){1'b0}}, state_i.channel};
  assign tch_ext  = {{(FreqW-TunerW){1'b0}}, tch_d};
  // x5 and x25 as shift-and-add.
  assign freq_d   = fm_d ? (FM_BASE_KHZ + (tch_ext << 4) + (tch_ext << 3) + tch_ext)
                         : ((chan_ext << 2) + chan_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (state_ready_o) begin
      valid_q <= state_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q  <= state_i;
      fm_q   <= fm_d;
      tch_q  <= tch_d;
      freq_q <= freq_d;
    end
  end

  assign out_valid_o     = valid_q;
  assign channel_o       = res_q.channel;
  assign step_size_o     = res_q.step_size;
  assign volume_o        = res_q.volume;
  assign fm_band_o       = fm_q;
  assign tuner_channel_o = tch_q;
  assign disp_freq_o     = freq_q;

endmodule

`default_nettype wire

>>> rtl/tfp_checker.sv
// Port-level assertions for the tuner front-panel controller, bound to the top level.
`default_nettype none

module tfp_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         cfg_we_i,
  input wire logic [tfp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input wire logic [tfp_pkg::CfgDataW-1:0] cfg_data_i,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire logic [tfp_pkg::FuncW-1:0]    func_i,
  input wire logic                         direction_pin_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [tfp_pkg::ChanW-1:0]    channel_o,
  input wire logic [tfp_pkg::StepW-1:0]    step_size_o,
  input wire logic [tfp_pkg::VolW-1:0]     volume_o,
  input wire logic                         fm_band_o,
  input wire logic [tfp_pkg::TunerW-1:0]   tuner_channel_o,
  input wire logic [tfp_pkg::FreqW-1:0]    disp_freq_o
);
  import tfp_pkg::*;

  // A stalled result keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(channel_o)
      && $stable(step_size_o) && $stable(volume_o) && $stable(disp_freq_o))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> step_size_o == STEP_1 || step_size_o == STEP_10
      || step_size_o == STEP_100)
    else $error("step size outside 1/10/100");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fm_band_o == (channel_o >= FM_BASE_CHAN))
    else $error("band flag disagrees with channel");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !fm_band_o |-> {1'b0, tuner_channel_o} == channel_o
      && disp_freq_o == 18'({4'd0, channel_o} * 18'd5))
    else $error("lower band mapping wrong");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fm_band_o |-> {1'b0, tuner_channel_o} <= FM_TUNER_CAP
      && disp_freq_o == 18'(FM_BASE_KHZ + {5'd0, tuner_channel_o} * 18'd25))
    else $error("FM band mapping wrong");

endmodule

bind tuner_front_panel_controller_unit tfp_checker u_tfp_checker (.*);

`default_nettype wire

>>> dv/tfp_checker.sv
// Scoreboard for the tuner front-panel controller: predicts each readout and compares it.
module tfp_scoreboard (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [tfp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [tfp_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                         in_valid_i,
  input  wire logic                         in_ready_i,
  input  wire logic [tfp_pkg::FuncW-1:0]    func_i,
  input  wire logic                         direction_pin_i,
  input  wire logic                         out_valid_i,
  input  wire logic                         out_ready_i,
  input  wire logic [tfp_pkg::ChanW-1:0]    channel_i,
  input  wire logic [tfp_pkg::StepW-1:0]    step_size_i,
  input  wire logic [tfp_pkg::VolW-1:0]     volume_i,
  input  wire logic                         fm_band_i,
  input  wire logic [tfp_pkg::TunerW-1:0]   tuner_channel_i,
  input  wire logic [tfp_pkg::FreqW-1:0]    disp_freq_i,
  output int                                errors_o,
  output int                                pending_o,
  output int                                readouts_o,
  output int                                actions_o
);
  import tfp_pkg::*;

  localparam int unsigned TunerOffset = 400;
  localparam int unsigned FmKhzPerChan = 25;
  localparam int unsigned AmKhzPerChan = 5;

  typedef struct packed {
    logic [ChanW-1:0]  channel;
    logic [StepW-1:0]  step_size;
    logic [VolW-1:0]   volume;
    logic              fm_band;
    logic [TunerW-1:0] tuner_channel;
    logic [FreqW-1:0]  disp_freq;
  } readout_t;

  panel_cfg_t       regs;
  logic [ChanW-1:0] chan;
  logic [StepW-1:0] step;
  logic [VolW-1:0]  vol;
  logic [GateW-1:0] gate_cnt;
  logic             tune_held, vol_held, tune_open, step_open, vol_open;
  readout_t         expected_readouts[$];

  // Panel state after one event, following the controller's rules.
  task automatic apply_event(input logic [FuncW-1:0] code, input logic pin);
    int c;
    case (code)
      EV_TICK: begin
        if (gate_cnt == '0) begin
          tune_open = 1'b1;
          step_open = 1'b1;
          vol_open  = 1'b1;
        end
        if (int'(gate_cnt) + 1 >= int'(regs.gate_ticks)) gate_cnt = '0;
        else gate_cnt = gate_cnt + 1'b1;
      end
      EV_TUNE_EDGE: begin
        if (!tune_held) begin
          tune_held = 1'b1;
          if (tune_open) begin
            tune_open = 1'b0;
            c = int'(chan);
            if (pin) begin
              c = c + int'(step);
              if (c >= int'(regs.chan_upper)) c = int'(regs.chan_upper);
            end else begin
              c = c - int'(step);
              if (c < int'(regs.chan_lower)) c = int'(regs.chan_lower);
            end
            chan = c[ChanW-1:0];
            actions_o++;
          end
        end
      end
      EV_TUNE_REL: tune_held = 1'b0;
      EV_STEP_BUTTON: begin
        if (step_open) begin
          step_open = 1'b0;
          if (step == STEP_1) step = STEP_10;
          else if (step == STEP_10) step = STEP_100;
          else step = STEP_1;
          actions_o++;
        end
      end
      EV_VOL_EDGE: begin
        if (!vol_held) begin
          vol_held = 1'b1;
          if (vol_open) begin
            vol_open = 1'b0;
            c = int'(vol);
            // The volume knob counts up when the pin is low.
            if (!pin) begin
              c = c + int'(VOL_STEP);
              if (c >= int'(regs.vol_upper)) c = int'(regs.vol_upper);
            end else begin
              c = c - int'(VOL_STEP);
              if (c < int'(regs.vol_lower)) c = int'(regs.vol_lower);
            end
            vol = c[VolW-1:0];
            actions_o++;
          end
        end
      end
      EV_VOL_REL: vol_held = 1'b0;
      default: ;
    endcase
  endtask

  function automatic readout_t panel_readout();
    readout_t    r;
    int unsigned tch;
    int unsigned freq;
    r.channel   = chan;
    r.step_size = step;
    r.volume    = vol;
    if (chan < FM_BASE_CHAN) begin
      r.fm_band = 1'b0;
      tch  = chan;
      freq = int'(chan) * AmKhzPerChan;
    end else begin
      r.fm_band = 1'b1;
      if (chan >= regs.chan_upper) begin
        tch = FM_TUNER_CAP;
      end else begin
        tch = TunerOffset + int'(chan) - int'(FM_BASE_CHAN);
        if (tch > FM_TUNER_CAP) tch = FM_TUNER_CAP;
      end
      freq = FM_BASE_KHZ + tch * FmKhzPerChan;
    end
    r.tuner_channel = tch[TunerW-1:0];
    r.disp_freq     = freq[FreqW-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    readout_t want;
    if (!rst_ni) begin
      regs.chan_upper = CHAN_UPPER_RST;
      regs.chan_lower = CHAN_LOWER_RST;
      regs.vol_upper  = VOL_UPPER_RST;
      regs.vol_lower  = VOL_LOWER_RST;
      regs.gate_ticks = GATE_TICKS_RST;
      chan      = CHAN_RST;
      step      = STEP_RST;
      vol       = VOL_RST;
      gate_cnt  = '0;
      tune_held = 1'b0;
      vol_held  = 1'b0;
      tune_open = 1'b0;
      step_open = 1'b0;
      vol_open  = 1'b0;
      expected_readouts.delete();
      errors_o   = 0;
      pending_o  = 0;
      readouts_o = 0;
      actions_o  = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_readouts.size() == 0) begin
          $error("readout transfer with nothing expected: channel %0d", channel_i);
          errors_o++;
        end else begin
          want = expected_readouts.pop_front();
          check_field("channel", want.channel, channel_i);
          check_field("step_size", want.step_size, step_size_i);
          check_field("volume", want.volume, volume_i);
          check_field("fm_band", want.fm_band, fm_band_i);
          check_field("tuner_channel", want.tuner_channel, tuner_channel_i);
          check_field("disp_freq", want.disp_freq, disp_freq_i);
          readouts_o++;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CHAN_UPPER: regs.chan_upper = cfg_data_i[ChanW-1:0];
          CFG_CHAN_LOWER: regs.chan_lower = cfg_data_i[ChanW-1:0];
          CFG_VOL_UPPER:  regs.vol_upper  = cfg_data_i[VolW-1:0];
          CFG_VOL_LOWER:  regs.vol_lower  = cfg_data_i[VolW-1:0];
          CFG_GATE_TICKS: regs.gate_ticks = cfg_data_i[GateW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        apply_event(func_i, direction_pin_i);
        expected_readouts.push_back(panel_readout());
      end
      pending_o = expected_readouts.size();
    end
  end

endmodule

>>> dv/tb.sv
// Testbench top for the tuner front-panel controller: stimulus, flow control and verdict.
module tb;
  import tfp_pkg::*;

  localparam logic [FuncW-1:0] EV_SPARE_6 = 3'd6;
  localparam logic [FuncW-1:0] EV_SPARE_7 = 3'd7;
  localparam int PhaseCount = 19;
  localparam int PhaseEvents = 100;
  localparam int LongHoldCycles = 64;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  logic                ev_valid;
  logic                ev_ready;
  logic [FuncW-1:0]    ev_func;
  logic                ev_pin;
  logic                rd_valid;
  logic                rd_ready;
  logic [ChanW-1:0]    rd_channel;
  logic [StepW-1:0]    rd_step;
  logic [VolW-1:0]     rd_volume;
  logic                rd_fm;
  logic [TunerW-1:0]   rd_tuner;
  logic [FreqW-1:0]    rd_freq;

  int errors, pending, readouts, actions;
  int events_sent, setups, phase_sent, gap_pct, rx_pct, settle_wait;
  bit calm, no_gaps, rx_hold_req;

  tuner_front_panel_controller_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (ev_valid),
    .in_ready_o     (ev_ready),
    .func_i         (ev_func),
    .direction_pin_i(ev_pin),
    .out_valid_o    (rd_valid),
    .out_ready_i    (rd_ready),
    .channel_o      (rd_channel),
    .step_size_o    (rd_step),
    .volume_o       (rd_volume),
    .fm_band_o      (rd_fm),
    .tuner_channel_o(rd_tuner),
    .disp_freq_o    (rd_freq)
  );

  tfp_scoreboard u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (ev_valid),
    .in_ready_i     (ev_ready),
    .func_i         (ev_func),
    .direction_pin_i(ev_pin),
    .out_valid_i    (rd_valid),
    .out_ready_i    (rd_ready),
    .channel_i      (rd_channel),
    .step_size_i    (rd_step),
    .volume_i       (rd_volume),
    .fm_band_i      (rd_fm),
    .tuner_channel_i(rd_tuner),
    .disp_freq_i    (rd_freq),
    .errors_o       (errors),
    .pending_o      (pending),
    .readouts_o     (readouts),
    .actions_o      (actions)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // Readout side: random stalls, plus one long hold-off on request.
  initial begin
    int stall_cycles;
    rd_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      stall_cycles = 0;
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall_cycles = LongHoldCycles;
      end else if (!calm && $urandom_range(0, 99) < rx_pct) begin
        stall_cycles = $urandom_range(1, 18);
      end
      if (stall_cycles > 0) begin
        rd_ready <= 1'b0;
        repeat (stall_cycles) @(posedge clk);
      end
      rd_ready <= 1'b1;
    end
  end

  function automatic logic rand_pin();
    return 1'($urandom_range(0, 1));
  endfunction

  // One event transfer; valid stays up until the block takes it.
  task automatic send_event(input logic [FuncW-1:0] code, input logic pin);
    if (!calm && !no_gaps && $urandom_range(0, 99) < gap_pct) begin
      ev_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    ev_valid <= 1'b1;
    ev_func  <= code;
    ev_pin   <= pin;
    do @(posedge clk); while (!ev_ready);
    events_sent++;
    phase_sent++;
  endtask

  // Stop offering events and let every readout drain before touching registers.
  task automatic drain();
    ev_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure_panel(input int cu, input int cl, input int vu, input int vl,
                                 input int gt);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_CHAN_UPPER;
    cfg_data <= CfgDataW'(cu);
    @(posedge clk);
    cfg_idx  <= CFG_CHAN_LOWER;
    cfg_data <= CfgDataW'(cl);
    @(posedge clk);
    cfg_idx  <= CFG_VOL_UPPER;
    cfg_data <= CfgDataW'(vu);
    @(posedge clk);
    cfg_idx  <= CFG_VOL_LOWER;
    cfg_data <= CfgDataW'(vl);
    @(posedge clk);
    cfg_idx  <= CFG_GATE_TICKS;
    cfg_data <= CfgDataW'(gt);
    @(posedge clk);
    cfg_we   <= 1'b0;
    setups++;
  endtask

  // Mostly realistic knob and button gestures, with some bounce and broken sequences.
  task automatic panel_gesture();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      repeat ($urandom_range(1, 4)) send_event(EV_TICK, rand_pin());
    end else if (pick < 48) begin
      send_event(EV_TUNE_EDGE, rand_pin());
      repeat ($urandom_range(0, 2)) send_event(EV_TUNE_EDGE, rand_pin());
      send_event(EV_TUNE_REL, rand_pin());
    end else if (pick < 60) begin
      send_event(EV_STEP_BUTTON, rand_pin());
    end else if (pick < 80) begin
      send_event(EV_VOL_EDGE, rand_pin());
      repeat ($urandom_range(0, 2)) send_event(EV_VOL_EDGE, rand_pin());
      send_event(EV_VOL_REL, rand_pin());
    end else if (pick < 90) begin
      send_event(FuncW'($urandom_range(0, 7)), rand_pin());
    end else begin
      case ($urandom_range(0, 3))
        0: send_event(EV_TUNE_EDGE, rand_pin());
        1: send_event(EV_TUNE_REL, rand_pin());
        2: send_event(EV_VOL_EDGE, rand_pin());
        default: send_event(EV_VOL_REL, rand_pin());
      endcase
    end
  endtask

  task automatic setup_for_phase(input int k);
    int cu, cl, vu, vl, gt;
    case (k)
      0: configure_panel(15600, 40, 62, 20, 50);
      1: configure_panel(15600, 0, 63, 0, 1);
      2: configure_panel(0, 0, 0, 0, 1000);
      // The gate counter is well past three after the previous phase.
      3: configure_panel($urandom_range(8000, 15600), $urandom_range(0, 8000),
                         $urandom_range(32, 63), $urandom_range(0, 31), 3);
      4: configure_panel(15600, 15600, 63, 63, 1);
      default: begin
        cu = (k % 3 == 0) ? $urandom_range(7700, 8400) : $urandom_range(0, 15600);
        cl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15600) : $urandom_range(0, cu);
        vu = $urandom_range(0, 63);
        vl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, vu);
        gt = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 1000) : $urandom_range(1, 6);
        configure_panel(cu, cl, vu, vl, gt);
      end
    endcase
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = CFG_CHAN_UPPER;
    cfg_data    = '0;
    ev_valid    = 1'b0;
    ev_func     = EV_TICK;
    ev_pin      = 1'b0;
    calm        = 1'b0;
    no_gaps     = 1'b0;
    rx_hold_req = 1'b0;
    gap_pct     = 0;
    rx_pct      = 0;
    events_sent = 0;
    setups      = 0;
    phase_sent  = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: gating, held edges, step cycling, spare codes.
    configure_panel(15600, 40, 62, 20, 1);
    send_event(EV_TUNE_EDGE, 1'b1);    // gate still closed after reset
    send_event(EV_TUNE_REL, 1'b0);
    send_event(EV_TICK, 1'b0);
    send_event(EV_TUNE_EDGE, 1'b1);
    send_event(EV_TUNE_EDGE, 1'b0);    // held until released
    send_event(EV_TUNE_REL, 1'b1);
    send_event(EV_STEP_BUTTON, 1'b0);
    send_event(EV_STEP_BUTTON, 1'b1);  // second press in the same gate period
    send_event(EV_TICK, 1'b1);
    send_event(EV_STEP_BUTTON, 1'b0);
    send_event(EV_TICK, 1'b0);
    send_event(EV_STEP_BUTTON, 1'b0);
    send_event(EV_VOL_EDGE, 1'b0);
    send_event(EV_VOL_REL, 1'b0);
    send_event(EV_SPARE_6, 1'b1);
    send_event(EV_SPARE_7, 1'b0);
    drain();

    // Lower bounds above upper bounds and a zero gate.
    configure_panel(8000, 15600, 0, 63, 0);
    send_event(EV_TICK, 1'b0);
    send_event(EV_TUNE_EDGE, 1'b1);
    send_event(EV_TUNE_REL, 1'b0);
    send_event(EV_VOL_EDGE, 1'b0);
    send_event(EV_VOL_REL, 1'b1);
    send_event(EV_TICK, 1'b1);
    send_event(EV_TUNE_EDGE, 1'b0);
    send_event(EV_VOL_EDGE, 1'b1);
    drain();

    for (int k = 0; k < PhaseCount; k++) begin
      setup_for_phase(k);
      calm    = (k >= PhaseCount - 3);
      gap_pct = (k % 4 == 0) ? 0 : $urandom_range(5, 40);
      rx_pct  = (k % 4 == 1) ? 0 : $urandom_range(5, 40);
      phase_sent = 0;
      if (k == 5) begin
        // Hold the readout side while events keep coming back to back.
        no_gaps     = 1'b1;
        rx_hold_req = 1'b1;
        while (phase_sent < 40) panel_gesture();
        no_gaps = 1'b0;
      end
      while (phase_sent < PhaseEvents) panel_gesture();
      drain();
    end

    for (settle_wait = 0; settle_wait < 2000 && pending != 0; settle_wait++) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("tb: %0d panel events over %0d register setups, %0d readouts compared",
             events_sent, setups, readouts);
    $display("tb: %0d tune, step and volume actions took effect", actions);
    if (errors == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/tfp_pkg.sv
rtl/tfp_ctrl.sv
rtl/tfp_freq_map.sv
rtl/tuner_front_panel_controller_unit.sv
rtl/tfp_checker.sv
dv/tfp_checker.sv
dv/tb.sv
